// File: design/pdvc_pkg.sv
// Package for the packet delay value counter: shared widths, constants,
// the chain token type and the control state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdvc_pkg;

    // table size and field widths
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_W     = 35;
    localparam int COUNT_W     = 32;
    localparam int TIME_W      = 64;
    localparam int MARKER_W    = 32;
    localparam int INDEX_W     = 6;
    localparam int USED_OUT_W  = 7;

    // derived widths
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

    // delay scaling: one unit is 1e9 ticks, and 1e9 = 2^9 * 5^9
    localparam logic [TIME_W-1:0] NS_PER_UNIT = 64'd1000000000;
    // floor(x / 1e9) = ((x >> 9) * RECIP_M) >> 76, RECIP_M = ceil(2^76 / 5^9)
    localparam int DIV_PRESHIFT = 9;
    localparam int RECIP_IN_W   = TIME_W - DIV_PRESHIFT;
    localparam int RECIP_M_W    = 56;
    localparam int RECIP_SHIFT  = 76;
    localparam int PROD_W       = RECIP_IN_W + RECIP_M_W;
    localparam logic [RECIP_M_W-1:0] RECIP_M = 56'd38685626227668134;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // operation codes of an input word
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // kind of work a token carries down the cell chain
    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_RECORD,
        TOK_READ
    } tok_kind_t;

    // token handed from cell to cell
    typedef struct packed {
        logic                  active;
        tok_kind_t             kind;
        logic [VALUE_W-1:0]    key;
        logic [INDEX_W-1:0]    idx;
        logic                  hit;
        logic                  fresh;
        logic [VALUE_W-1:0]    value;
        logic [COUNT_W-1:0]    count;
    } tok_t;

    // top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHAIN,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

// File: design/pdvc_div.sv
// Divider by the constant 1e9 as a reciprocal multiply, four 32 by 32 partial
// products accumulated one per cycle. Depends on pdvc_pkg for the constants.
`timescale 1ns / 1ps
`default_nettype none

module pdvc_div
    import pdvc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [TIME_W-1:0]  dividend,
    output logic                    done,
    output logic [VALUE_W-1:0]      quotient
);

    logic [RECIP_IN_W-1:0] num_reg,  num_next;
    logic [PROD_W-1:0]     acc_reg,  acc_next;
    logic [1:0]            step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [31:0]           op_a;
    logic [31:0]           op_b;
    logic [63:0]           part;
    logic [PROD_W-1:0]     part_sh;

    // partial product of this step: low/high halves of numerator and reciprocal
    always_comb begin
        op_a = step_reg[1] ? 32'(num_reg[RECIP_IN_W-1:32]) : num_reg[31:0];
        op_b = step_reg[0] ? 32'(RECIP_M[RECIP_M_W-1:32]) : RECIP_M[31:0];
        part = 64'(op_a) * 64'(op_b);
        case (step_reg)
            2'd0: begin
                part_sh = PROD_W'(part);
            end
            2'd3: begin
                part_sh = PROD_W'(part) << 64;
            end
            default: begin
                part_sh = PROD_W'(part) << 32;
            end
        endcase
    end

    // load the numerator, then accumulate one partial product per cycle
    always_comb begin
        num_next  = num_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend[TIME_W-1:DIV_PRESHIFT];
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + part_sh;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    // control flags reset, datapath free running
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[RECIP_SHIFT +: VALUE_W];

endmodule

`default_nettype wire

// File: design/pdvc_cell.sv
// One table cell: holds a delay value and its hit count, acts on the token
// passing by and hands it to the next cell. Depends on pdvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdvc_cell
    import pdvc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [ADDR_W-1:0]  cell_idx,
    input  wire logic [USED_W-1:0]  used,
    input  wire tok_t               tok_in,
    output tok_t                    tok_out
);

    logic [VALUE_W-1:0] val_reg, val_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    tok_t               tok_reg, tok_next;
    logic               in_use;
    logic               is_free;
    logic               idx_match;

    // search, count, append or read out as the token goes past
    always_comb begin
        tok_next  = tok_in;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        in_use    = USED_W'(cell_idx) < used;
        is_free   = USED_W'(cell_idx) == used;
        idx_match = CMP_W'(tok_in.idx) == CMP_W'(cell_idx);
        if (tok_in.active) begin
            case (tok_in.kind)
                TOK_RECORD: begin
                    if (in_use && (val_reg == tok_in.key)) begin
                        tok_next.hit = 1'b1;
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end else if (is_free && !tok_in.hit) begin
                        val_next       = tok_in.key;
                        cnt_next       = COUNT_W'(1);
                        tok_next.fresh = 1'b1;
                    end
                end
                TOK_READ: begin
                    if (in_use && idx_match) begin
                        tok_next.hit   = 1'b1;
                        tok_next.value = val_reg;
                        tok_next.count = cnt_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // token valid flag resets, stored entry does not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
        val_reg <= val_next;
        cnt_reg <= cnt_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: design/packet_delay_value_counter_top.sv
// Top level of the packet delay value counter: control, divider and cell chain.
// Depends on pdvc_pkg, pdvc_div and pdvc_cell.
//
// Usage:
//   Input words arrive on s_valid/s_ready with the operation, marker word,
//   arrival and current time and read index. Each word gives one result word
//   on m_valid/m_ready. The user must write the marker register through cfg_we
//   and cfg_wdata only while the block is idle; the block does not enforce it.
//   A record word whose marker matches and whose current time is later first
//   goes through the divider by 1e9 (a reciprocal multiply, four partial
//   products, one per cycle), then a token walks the row of TABLE_DEPTH
//   cells, one cell per cycle, and its result goes to the output register.
//   Read words and non-matching record words skip the divider. Words are
//   handled one at a time: no new word is taken until the last word's
//   result is loaded into the output register.
//   The next word is taken while a finished result still waits in the output
//   register; a stalled receiver holds that word's result in the block until
//   the output register frees up, and no further word is taken meanwhile.
//   Reset empties the table (used count zero), clears the marker register and
//   drops any word in flight. Table entries are only read once written.
`timescale 1ns / 1ps
`default_nettype none

module packet_delay_value_counter_top
    import pdvc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [MARKER_W-1:0]    cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_operation,
    input  wire logic [MARKER_W-1:0]    s_marker_word,
    input  wire logic [TIME_W-1:0]      s_arrive_time,
    input  wire logic [TIME_W-1:0]      s_now_time,
    input  wire logic [INDEX_W-1:0]     s_read_index,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_recorded,
    output logic                        m_new_entry,
    output logic                        m_table_full,
    output logic                        m_entry_valid,
    output logic [VALUE_W-1:0]          m_entry_value,
    output logic [COUNT_W-1:0]          m_entry_count,
    output logic [USED_OUT_W-1:0]       m_used_entries
);

    state_t              state_reg, state_next;
    logic [MARKER_W-1:0] marker_reg;
    logic [USED_W-1:0]   used_reg,  used_next;
    tok_t                launch_reg, launch_next;
    tok_t                end_reg,   end_next;
    tok_t                chain [TABLE_DEPTH+1];

    logic                m_valid_reg, m_valid_next;
    logic                rec_reg, rec_next;
    logic                new_reg, new_next;
    logic                full_reg, full_next;
    logic                ev_reg, ev_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [USED_OUT_W-1:0] used_out_reg, used_out_next;

    logic                sample_ok;
    logic                div_start;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quo;
    logic [TIME_W-1:0]   delta;
    logic                is_rec;
    logic                out_free;

    // delay span of the incoming word
    assign delta     = s_now_time - s_arrive_time;
    assign sample_ok = (s_marker_word == marker_reg) && (s_now_time > s_arrive_time);
    assign out_free  = !m_valid_reg || m_ready;

    pdvc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (delta),
        .done     (div_done),
        .quotient (div_quo)
    );

    // row of table cells
    assign chain[0] = launch_reg;
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        pdvc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (ADDR_W'(i)),
            .used     (used_reg),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    // next state, token launch and result formatting
    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        end_next      = end_reg;
        s_ready       = 1'b0;
        div_start     = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        rec_next      = rec_reg;
        new_next      = new_reg;
        full_next     = full_reg;
        ev_next       = ev_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        used_out_next = used_out_reg;
        is_rec        = end_reg.kind == TOK_RECORD;

        launch_next        = '0;
        launch_next.kind   = TOK_NONE;
        launch_next.idx    = s_read_index;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_READ) begin
                        launch_next.active = 1'b1;
                        launch_next.kind   = TOK_READ;
                        state_next         = ST_CHAIN;
                    end else if (sample_ok) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        launch_next.active = 1'b1;
                        state_next         = ST_CHAIN;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    launch_next.active = 1'b1;
                    launch_next.kind   = TOK_RECORD;
                    launch_next.key    = div_quo;
                    state_next         = ST_CHAIN;
                end
            end
            ST_CHAIN: begin
                if (chain[TABLE_DEPTH].active) begin
                    end_next   = chain[TABLE_DEPTH];
                    state_next = ST_LOAD;
                    if (chain[TABLE_DEPTH].fresh) begin
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    rec_next      = is_rec && (end_reg.hit || end_reg.fresh);
                    new_next      = is_rec && end_reg.fresh;
                    full_next     = is_rec && !end_reg.hit && !end_reg.fresh;
                    ev_next       = (end_reg.kind == TOK_READ) && end_reg.hit;
                    val_next      = end_reg.value;
                    cnt_next      = end_reg.count;
                    used_out_next = USED_OUT_W'(used_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg          <= '0;
            marker_reg        <= '0;
            launch_reg.active <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            used_reg    <= used_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                marker_reg <= cfg_wdata;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        end_reg      <= end_next;
        rec_reg      <= rec_next;
        new_reg      <= new_next;
        full_reg     <= full_next;
        ev_reg       <= ev_next;
        val_reg      <= val_next;
        cnt_reg      <= cnt_next;
        used_out_reg <= used_out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_recorded     = rec_reg;
    assign m_new_entry    = new_reg;
    assign m_table_full   = full_reg;
    assign m_entry_valid  = ev_reg;
    assign m_entry_value  = val_reg;
    assign m_entry_count  = cnt_reg;
    assign m_used_entries = used_out_reg;

endmodule

`default_nettype wire

// File: tb/delay_table_checker.sv
// Checker for the packet delay value counter: watches the word and result channels,
// keeps its own copy of the delay table and compares every result field.
// Depends on pdvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module delay_table_checker
    import pdvc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [MARKER_W-1:0]   cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic                  s_operation,
    input  wire logic [MARKER_W-1:0]   s_marker_word,
    input  wire logic [TIME_W-1:0]     s_arrive_time,
    input  wire logic [TIME_W-1:0]     s_now_time,
    input  wire logic [INDEX_W-1:0]    s_read_index,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  m_recorded,
    input  wire logic                  m_new_entry,
    input  wire logic                  m_table_full,
    input  wire logic                  m_entry_valid,
    input  wire logic [VALUE_W-1:0]    m_entry_value,
    input  wire logic [COUNT_W-1:0]    m_entry_count,
    input  wire logic [USED_OUT_W-1:0] m_used_entries,
    output int                         fail_count,
    output int                         pending,
    output int                         fresh_total,
    output int                         repeat_total,
    output int                         drop_total
);

    // one result word as the block should give it
    typedef struct packed {
        logic                  recorded;
        logic                  new_entry;
        logic                  table_full;
        logic                  entry_valid;
        logic [VALUE_W-1:0]    entry_value;
        logic [COUNT_W-1:0]    entry_count;
        logic [USED_OUT_W-1:0] used_entries;
    } table_reply_t;

    // mirror of the delay table and the marker register
    logic [VALUE_W-1:0]  delay_tbl [TABLE_DEPTH];
    logic [COUNT_W-1:0]  hits_tbl  [TABLE_DEPTH];
    int unsigned         fill;
    logic [MARKER_W-1:0] marker_reg;

    table_reply_t awaited_replies [$];
    int mismatches;
    int fresh_n;
    int repeat_n;
    int drop_n;

    initial begin
        fill       = 0;
        marker_reg = '0;
        mismatches = 0;
        fresh_n    = 0;
        repeat_n   = 0;
        drop_n     = 0;
        fail_count = 0;
        pending    = 0;
        fresh_total  = 0;
        repeat_total = 0;
        drop_total   = 0;
    end

    // update the table copy for one accepted word and give its reply
    task automatic tally_word(input logic op, input logic [MARKER_W-1:0] marker,
                              input logic [TIME_W-1:0] arrive, input logic [TIME_W-1:0] now,
                              input logic [INDEX_W-1:0] idx, output table_reply_t reply);
        logic [VALUE_W-1:0] delay;
        logic               found;
        int                 k;
        reply = '0;
        if (op == OP_READ) begin
            if (idx < fill) begin
                reply.entry_valid = 1'b1;
                reply.entry_value = delay_tbl[ADDR_W'(idx)];
                reply.entry_count = hits_tbl[ADDR_W'(idx)];
            end
        end else if (marker == marker_reg && now > arrive) begin
            delay = VALUE_W'((now - arrive) / NS_PER_UNIT);
            found = 1'b0;
            for (k = 0; k < TABLE_DEPTH; k++) begin
                if (!found && k < fill && delay_tbl[ADDR_W'(k)] == delay) begin
                    found = 1'b1;
                    if (hits_tbl[ADDR_W'(k)] != COUNT_MAX)
                        hits_tbl[ADDR_W'(k)] = hits_tbl[ADDR_W'(k)] + 1'b1;
                end
            end
            if (found) begin
                reply.recorded = 1'b1;
                repeat_n++;
            end else if (fill < TABLE_DEPTH) begin
                delay_tbl[ADDR_W'(fill)] = delay;
                hits_tbl[ADDR_W'(fill)]  = COUNT_W'(1);
                fill++;
                reply.recorded  = 1'b1;
                reply.new_entry = 1'b1;
                fresh_n++;
            end else begin
                reply.table_full = 1'b1;
                drop_n++;
            end
        end
        reply.used_entries = USED_OUT_W'(fill);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        table_reply_t want;
        if (!aresetn) begin
            fill       = 0;
            marker_reg = '0;
            awaited_replies.delete();
        end else begin
            if (cfg_we)
                marker_reg = cfg_wdata;
            // results first: a word taken at this edge cannot have its reply yet
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("result word with no word waiting for it");
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("recorded", 64'(want.recorded), 64'(m_recorded));
                    compare_field("new_entry", 64'(want.new_entry), 64'(m_new_entry));
                    compare_field("table_full", 64'(want.table_full), 64'(m_table_full));
                    compare_field("entry_valid", 64'(want.entry_valid),
                                  64'(m_entry_valid));
                    compare_field("entry_value", 64'(want.entry_value),
                                  64'(m_entry_value));
                    compare_field("entry_count", 64'(want.entry_count),
                                  64'(m_entry_count));
                    compare_field("used_entries", 64'(want.used_entries),
                                  64'(m_used_entries));
                end
            end
            if (s_valid && s_ready) begin
                tally_word(s_operation, s_marker_word, s_arrive_time, s_now_time,
                           s_read_index, want);
                awaited_replies.insert(awaited_replies.size(), want);
            end
        end
        // copies for the top, settled after this edge
        pending      <= awaited_replies.size();
        fail_count   <= mismatches;
        fresh_total  <= fresh_n;
        repeat_total <= repeat_n;
        drop_total   <= drop_n;
    end

endmodule

`default_nettype wire

// File: tb/packet_delay_value_counter_top_tb.sv
// Testbench top for the packet delay value counter: clock, reset, marker writes,
// word stimulus and result back-pressure, and the verdict.
// Depends on pdvc_pkg, packet_delay_value_counter_top and delay_table_checker.
`timescale 1ns / 1ps
`default_nettype none

module packet_delay_value_counter_top_tb;
    import pdvc_pkg::*;

    localparam int  CYCLE_LIMIT  = 1200000;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  PHASES       = 5;
    localparam int  PHASE_WORDS  = 190;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    // largest delay the time range can give
    localparam logic [TIME_W-1:0] DELAY_SPAN = 64'd18446744073;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [MARKER_W-1:0]   cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_RECORD;
    logic [MARKER_W-1:0]   s_marker_word = '0;
    logic [TIME_W-1:0]     s_arrive_time = '0;
    logic [TIME_W-1:0]     s_now_time = '0;
    logic [INDEX_W-1:0]    s_read_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_recorded;
    logic                  m_new_entry;
    logic                  m_table_full;
    logic                  m_entry_valid;
    logic [VALUE_W-1:0]    m_entry_value;
    logic [COUNT_W-1:0]    m_entry_count;
    logic [USED_OUT_W-1:0] m_used_entries;

    int fail_count;
    int pending;
    int fresh_total;
    int repeat_total;
    int drop_total;

    int cycles = 0;
    int taken = 0;
    bit quiet = 1'b0;
    int n_samples = 0;
    int n_reads = 0;
    int n_settings = 1;
    logic [MARKER_W-1:0] marker_now = '0;
    logic [VALUE_W-1:0]  seen_delays [$];

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    packet_delay_value_counter_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_marker_word  (s_marker_word),
        .s_arrive_time  (s_arrive_time),
        .s_now_time     (s_now_time),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_recorded     (m_recorded),
        .m_new_entry    (m_new_entry),
        .m_table_full   (m_table_full),
        .m_entry_valid  (m_entry_valid),
        .m_entry_value  (m_entry_value),
        .m_entry_count  (m_entry_count),
        .m_used_entries (m_used_entries)
    );

    delay_table_checker table_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_marker_word  (s_marker_word),
        .s_arrive_time  (s_arrive_time),
        .s_now_time     (s_now_time),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_recorded     (m_recorded),
        .m_new_entry    (m_new_entry),
        .m_table_full   (m_table_full),
        .m_entry_valid  (m_entry_valid),
        .m_entry_value  (m_entry_value),
        .m_entry_count  (m_entry_count),
        .m_used_entries (m_used_entries),
        .fail_count     (fail_count),
        .pending        (pending),
        .fresh_total    (fresh_total),
        .repeat_total   (repeat_total),
        .drop_total     (drop_total)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 16);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // offer one word after a random gap and wait until it is taken
    task automatic push_word(input logic op, input logic [MARKER_W-1:0] marker,
                             input logic [TIME_W-1:0] arrive, input logic [TIME_W-1:0] now,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_marker_word <= marker;
        s_arrive_time <= arrive;
        s_now_time    <= now;
        s_read_index  <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_READ)
            n_reads++;
        else
            n_samples++;
    endtask

    // marker register is only written with nothing in flight
    task automatic write_marker(input logic [MARKER_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        marker_now = value;
        n_settings++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // matching sample whose times give the wanted delay
    task automatic send_sample(input logic [VALUE_W-1:0] delay);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] arrive;
        logic [TIME_W-1:0] offset;
        int                roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            offset = 0;
        else if (roll == 1)
            offset = NS_PER_UNIT - 1;
        else
            offset = TIME_W'($urandom_range(0, 999999999));
        if (delay == 0 && offset == 0)
            offset = 1;
        base = {29'd0, delay} * NS_PER_UNIT;
        // keep the span inside the time range at the largest delay
        if (offset > TIME_MAX - base)
            offset = TIME_MAX - base;
        span = base + offset;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            arrive = '0;
        else if (roll == 1)
            arrive = ~span;
        else
            arrive = rand64() % (~span + 64'd1);
        push_word(OP_RECORD, marker_now, arrive, arrive + span, INDEX_W'($urandom));
    endtask

    // mostly delays seen before, sometimes a fresh one
    function automatic logic [VALUE_W-1:0] pick_delay();
        logic [VALUE_W-1:0] delay;
        int                 roll;
        roll = $urandom_range(0, 99);
        if (seen_delays.size() != 0 && roll >= 20)
            return seen_delays[$urandom_range(0, seen_delays.size() - 1)];
        roll = $urandom_range(0, 9);
        if (roll < 2)
            delay = VALUE_W'($urandom_range(0, 20));
        else if (roll < 5)
            delay = VALUE_W'($urandom_range(21, 100000));
        else
            delay = VALUE_W'(rand64() % DELAY_SPAN);
        seen_delays.insert(seen_delays.size(), delay);
        return delay;
    endfunction

    task automatic random_word();
        logic [TIME_W-1:0] a;
        int                roll;
        int                top_idx;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            send_sample(pick_delay());
        end else if (roll < 80) begin
            // reads aimed mostly at filled entries, the rest anywhere
            top_idx = (seen_delays.size() == 0) ? 63 :
                      (seen_delays.size() > 64) ? 63 : seen_delays.size() - 1;
            if ($urandom_range(0, 9) < 6)
                push_word(OP_READ, $urandom, rand64(), rand64(),
                          INDEX_W'($urandom_range(0, top_idx)));
            else
                push_word(OP_READ, $urandom, rand64(), rand64(),
                          INDEX_W'($urandom_range(0, 63)));
        end else begin
            // samples that must leave the table alone, plus plain noise
            a = rand64();
            case ($urandom_range(0, 3))
                0: push_word(OP_RECORD, marker_now ^ ($urandom | 32'h1 << $urandom_range(0, 31)),
                             a, a + NS_PER_UNIT, INDEX_W'($urandom));
                1: push_word(OP_RECORD, marker_now, a, a, INDEX_W'($urandom));
                2: begin
                    if (a == 0)
                        a = 1;
                    push_word(OP_RECORD, marker_now, a, rand64() % a, INDEX_W'($urandom));
                end
                default: push_word(OP_RECORD, $urandom, rand64(), rand64(),
                                   INDEX_W'($urandom));
            endcase
        end
    endtask

    // receiver: random stalls, and once a long hold so the block backs up
    initial begin : drain
        int stall;
        int run;
        bit pressed;
        pressed = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!pressed && taken >= 300) begin
                pressed = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            taken <= taken + 1;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped: still busy after %0d cycles", CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        logic [MARKER_W-1:0] setting;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words under the reset marker value
        push_word(OP_READ, '0, '0, '0, 6'd0);                         // empty table
        push_word(OP_READ, '1, '1, '1, 6'd63);
        push_word(OP_RECORD, '0, '0, 64'd1, 6'd0);                    // zero delay, new
        push_word(OP_RECORD, '0, '0, NS_PER_UNIT - 1, 6'd63);         // just under one unit
        push_word(OP_RECORD, '0, '0, NS_PER_UNIT, 6'd0);              // exactly one unit
        push_word(OP_RECORD, '0, '0, TIME_MAX, 6'd0);                 // largest delay
        push_word(OP_RECORD, '0, TIME_MAX - 1, TIME_MAX, 6'd0);       // zero delay at top of range
        push_word(OP_RECORD, '0, TIME_MAX, TIME_MAX, 6'd0);           // equal times
        push_word(OP_RECORD, '0, '0, '0, 6'd0);
        push_word(OP_RECORD, '0, TIME_MAX, '0, 6'd0);                 // time ran backwards
        push_word(OP_RECORD, '1, '0, TIME_MAX, 6'd0);                 // marker mismatch
        push_word(OP_RECORD, 32'h1, '0, NS_PER_UNIT, 6'd0);
        push_word(OP_RECORD, '0, 64'd1, TIME_MAX, 6'd0);              // largest delay again
        push_word(OP_READ, '0, '0, '0, 6'd0);
        push_word(OP_READ, '0, '0, '0, 6'd1);
        push_word(OP_READ, '0, '0, '0, 6'd2);
        push_word(OP_READ, '0, '0, '0, 6'd3);                         // first unused entry
        push_word(OP_READ, '0, '0, '0, 6'd63);
        seen_delays.insert(seen_delays.size(), VALUE_W'(0));
        seen_delays.insert(seen_delays.size(), VALUE_W'(1));
        seen_delays.insert(seen_delays.size(), VALUE_W'(DELAY_SPAN));

        // random phases, each under its own marker setting
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: setting = '1;
                2: setting = '0;
                4: setting = 32'h8000_0001;
                default: setting = $urandom;
            endcase
            write_marker(setting);
            quiet = (phase == 2);
            for (n = 0; n < PHASE_WORDS; n++)
                random_word();
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (TABLE_DEPTH + 40) @(posedge aclk);

        $display("%0d words sent (%0d samples, %0d reads) across %0d marker settings",
                 n_samples + n_reads, n_samples, n_reads, n_settings);
        $display("table saw %0d new delays, %0d repeats and %0d drops when full",
                 fresh_total, repeat_total, drop_total);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
